// ===== design/rstc_pkg.sv =====
// Shared widths, op codes, motion codes and register indexes for the shutter controller.
package rstc_pkg;

  localparam int OP_W      = 3;
  localparam int MOTION_W  = 2;
  localparam int TIME_W    = 8;
  localparam int POS_W     = 7;
  localparam int MEAS_W    = 20;
  localparam int MTIME_W   = 15;
  localparam int DIVS_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [OP_W-1:0] OP_ORDER  = 3'd0;
  localparam logic [OP_W-1:0] OP_BUTTON = 3'd1;
  localparam logic [OP_W-1:0] OP_TARGET = 3'd2;
  localparam logic [OP_W-1:0] OP_APPLY  = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;

  localparam logic [MOTION_W-1:0] MOTION_UP   = 2'd0;
  localparam logic [MOTION_W-1:0] MOTION_DOWN = 2'd1;
  localparam logic [MOTION_W-1:0] MOTION_STOP = 2'd2;

  localparam logic [POS_W-1:0] FULL_TRAVEL = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_UP_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEVEL = 2'd2;

endpackage

// ===== design/rstc_if.sv =====
// Request and result channel interfaces for the shutter controller.
interface rstc_in_if
  import rstc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]     op;
  logic [MOTION_W-1:0] order;
  logic [POS_W-1:0]    target_position;
  logic                direction;
  logic [MEAS_W-1:0]   measured_time;

  modport source (output valid, op, order, target_position, direction, measured_time,
                  input ready);
  modport sink (input valid, op, order, target_position, direction, measured_time,
                output ready);
endinterface

interface rstc_out_if
  import rstc_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [MTIME_W-1:0]  movement_time;
  logic [MOTION_W-1:0] motion_state;
  logic                up_relay;
  logic                down_relay;
  logic [POS_W-1:0]    position;

  modport source (output valid, movement_time, motion_state, up_relay, down_relay, position,
                  input ready);
  modport sink (input valid, movement_time, motion_state, up_relay, down_relay, position,
                output ready);
endinterface

// ===== design/rstc_mul.sv =====
// Bit-serial shift-add multiplier: travel time times distance, one multiplier bit per cycle.
module rstc_mul
  import rstc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TIME_W-1:0]  mcand,
  input  logic [POS_W-1:0]   mplier,
  output logic               done,
  output logic [MTIME_W-1:0] prod
);

  localparam int STEPS = POS_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               done_r;
  logic [MTIME_W-1:0] acc_r, acc_nxt;
  logic [MTIME_W-1:0] mcand_r, mcand_nxt;
  logic [POS_W-1:0]   mplier_r, mplier_nxt;

  always_comb begin
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (start) begin
      cnt_nxt    = CNT_W'(STEPS);
      acc_nxt    = '0;
      mcand_nxt  = MTIME_W'(mcand);
      mplier_nxt = mplier;
    end else if (cnt_r != '0) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[MTIME_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[POS_W-1:1]};
      cnt_nxt    = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= (cnt_r == CNT_W'(1));
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== design/rstc_div.sv =====
// Restoring divider: measured time over ten times travel time, one quotient bit per cycle.
module rstc_div
  import rstc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MEAS_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [MEAS_W-1:0] quot,
  output logic              rem_nz
);

  localparam int STEPS = MEAS_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [MEAS_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W:0]   trial;

  assign shifted = {rem_r, quo_r[MEAS_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = CNT_W'(STEPS);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      // keep the difference only when the divisor fits
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = trial[DIVS_W-1:0];
        quo_nxt = {quo_r[MEAS_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIVS_W-1:0];
        quo_nxt = {quo_r[MEAS_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= (cnt_r == CNT_W'(1));
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done   = done_r;
  assign quot   = quo_r;
  assign rem_nz = (rem_r != '0);

endmodule

// ===== design/roller_shutter_travel_controller.sv =====
// Roller-shutter travel controller: motion state, relay drive and position tracking.
// Order, button, apply and unused-op requests and a position update at zero travel time go
// straight to the finish state; a target position first runs a 7-step multiply, other
// updates a restoring divide. A new request is taken once the previous one has committed,
// even while its result still waits in the output register.
// Reset (synchronous, rst_n low): shutter stopped, position 0, relays off, registers 0.
module roller_shutter_travel_controller
  import rstc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  rstc_in_if.sink              in_req,
  rstc_out_if.source           out_rsp
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [TIME_W-1:0]   up_time_r, down_time_r;
  logic                off_level_r;
  logic [MOTION_W-1:0] pend_r, pend_nxt;
  logic [MOTION_W-1:0] applied_r, applied_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                up_drv_r, up_drv_nxt;
  logic                down_drv_r, down_drv_nxt;

  // latched request
  logic [OP_W-1:0]     op_r;
  logic [MOTION_W-1:0] order_r;
  logic                dir_r;
  logic                tgt_down_r;

  logic                out_valid_r;
  logic [MTIME_W-1:0]  out_mtime_r;
  logic [MOTION_W-1:0] out_motion_r;
  logic                out_up_r, out_down_r;
  logic [POS_W-1:0]    out_pos_r;

  logic               accept;
  logic               out_free;
  logic               commit;
  logic [POS_W-1:0]   tgt_sat;
  logic               tgt_down;
  logic [POS_W-1:0]   dist_pct;
  logic [TIME_W-1:0]  upd_time;
  logic               mul_start, mul_done;
  logic [MTIME_W-1:0] mul_prod;
  logic               div_start, div_done;
  logic [MEAS_W-1:0]  div_quot;
  logic               div_rem_nz;
  logic [DIVS_W-1:0]  divisor;
  logic [MTIME_W-1:0] mtime_nxt;
  logic [MEAS_W:0]    step_down, step_up;
  logic [TIME_W-1:0]  dir_time_r;

  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;
  assign commit   = (state_r == ST_FIN) && out_free;

  assign tgt_sat  = (in_req.target_position > FULL_TRAVEL) ? FULL_TRAVEL
                                                           : in_req.target_position;
  assign tgt_down = tgt_sat > pos_r;
  assign dist_pct = tgt_down ? (tgt_sat - pos_r) : (pos_r - tgt_sat);
  assign upd_time = in_req.direction ? down_time_r : up_time_r;
  assign divisor  = {1'b0, upd_time, 3'b000} + {3'b000, upd_time, 1'b0};

  assign mul_start = accept && (in_req.op == OP_TARGET);
  assign div_start = accept && (in_req.op == OP_UPDATE) && (upd_time != '0);

  rstc_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (tgt_down ? down_time_r : up_time_r),
    .mplier (dist_pct),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  rstc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_req.measured_time),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (mul_start) begin
            state_nxt = ST_MUL;
          end else if (div_start) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) state_nxt = ST_FIN;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign step_down = {1'b0, div_quot} + (MEAS_W+1)'(pos_r);
  assign step_up   = {1'b0, div_quot} + (MEAS_W+1)'(div_rem_nz);

  always_comb begin
    pend_nxt     = pend_r;
    applied_nxt  = applied_r;
    pos_nxt      = pos_r;
    up_drv_nxt   = up_drv_r;
    down_drv_nxt = down_drv_r;
    mtime_nxt    = '0;
    case (op_r)
      OP_ORDER, OP_BUTTON: begin
        if (applied_r != MOTION_STOP) begin
          pend_nxt = MOTION_STOP;
        end else if (order_r == MOTION_UP) begin
          pend_nxt  = MOTION_UP;
          mtime_nxt = MTIME_W'(up_time_r);
        end else if (order_r == MOTION_DOWN) begin
          pend_nxt  = MOTION_DOWN;
          mtime_nxt = MTIME_W'(down_time_r);
        end else begin
          pend_nxt = MOTION_STOP;
        end
      end
      OP_TARGET: begin
        pend_nxt  = tgt_down_r ? MOTION_DOWN : MOTION_UP;
        mtime_nxt = mul_prod;
      end
      OP_APPLY: begin
        up_drv_nxt   = (pend_r == MOTION_UP);
        down_drv_nxt = (pend_r == MOTION_DOWN);
        applied_nxt  = pend_r;
      end
      OP_UPDATE: begin
        if (dir_time_r == '0) begin
          pos_nxt = dir_r ? FULL_TRAVEL : '0;
        end else if (dir_r) begin
          pos_nxt = (step_down > (MEAS_W+1)'(FULL_TRAVEL)) ? FULL_TRAVEL
                                                           : step_down[POS_W-1:0];
        end else begin
          pos_nxt = (step_up > (MEAS_W+1)'(pos_r)) ? '0
                                                   : (pos_r - step_up[POS_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      up_time_r   <= '0;
      down_time_r <= '0;
      off_level_r <= 1'b0;
      pend_r      <= MOTION_STOP;
      applied_r   <= MOTION_STOP;
      pos_r       <= '0;
      up_drv_r    <= 1'b0;
      down_drv_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_UP_TIME:   up_time_r   <= cfg_wdata[TIME_W-1:0];
          CFG_DOWN_TIME: down_time_r <= cfg_wdata[TIME_W-1:0];
          CFG_OFF_LEVEL: off_level_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (commit) begin
        pend_r      <= pend_nxt;
        applied_r   <= applied_nxt;
        pos_r       <= pos_nxt;
        up_drv_r    <= up_drv_nxt;
        down_drv_r  <= down_drv_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      op_r       <= in_req.op;
      order_r    <= in_req.order;
      dir_r      <= in_req.direction;
      tgt_down_r <= tgt_down;
      dir_time_r <= upd_time;
    end
    if (commit) begin
      out_mtime_r  <= mtime_nxt;
      out_motion_r <= applied_nxt;
      out_up_r     <= up_drv_nxt ^ off_level_r;
      out_down_r   <= down_drv_nxt ^ off_level_r;
      out_pos_r    <= pos_nxt;
    end
  end

  assign in_req.ready          = (state_r == ST_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.movement_time = out_mtime_r;
  assign out_rsp.motion_state  = out_motion_r;
  assign out_rsp.up_relay      = out_up_r;
  assign out_rsp.down_relay    = out_down_r;
  assign out_rsp.position      = out_pos_r;

endmodule

// ===== design/rstc_check.sv =====
// Port-level checks for the shutter controller, bound to the top level.
module rstc_check
  import rstc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [MOTION_W-1:0] motion_state,
  input logic                up_relay,
  input logic                down_relay,
  input logic [POS_W-1:0]    position
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> position <= FULL_TRAVEL)
    else $error("position beyond full travel");

  a_stop_relays: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && motion_state == MOTION_STOP |-> up_relay == down_relay)
    else $error("relay driven while stopped");

  a_move_relays: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (motion_state == MOTION_UP || motion_state == MOTION_DOWN)
      |-> up_relay != down_relay)
    else $error("relays inconsistent with motion");

endmodule

bind roller_shutter_travel_controller rstc_check u_rstc_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .motion_state (out_rsp.motion_state),
  .up_relay     (out_rsp.up_relay),
  .down_relay   (out_rsp.down_relay),
  .position     (out_rsp.position)
);

// ===== sim/tb_roller_shutter_travel_controller.sv =====
// Self-checking testbench for the roller-shutter travel controller.
`timescale 1ns / 1ps

module tb_roller_shutter_travel_controller;
  import rstc_pkg::*;

  localparam logic [OP_W-1:0]     OP_SPARE5   = 3'd5;
  localparam logic [OP_W-1:0]     OP_SPARE6   = 3'd6;
  localparam logic [OP_W-1:0]     OP_SPARE7   = 3'd7;
  localparam logic [MOTION_W-1:0] ORDER_UNDEF = 2'd3;
  localparam logic [TIME_W-1:0]   ANY_TIME    = 8'hFF;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_MAX    = 10;
  localparam int ZERO_TIME_ROW = 24;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [MOTION_W-1:0] order;
    logic [POS_W-1:0]    target_position;
    logic                direction;
    logic [MEAS_W-1:0]   measured_time;
  } req_t;

  typedef struct packed {
    logic [MTIME_W-1:0]  movement_time;
    logic [MOTION_W-1:0] motion_state;
    logic                up_relay;
    logic                down_relay;
    logic [POS_W-1:0]    position;
  } status_t;

  typedef struct packed {
    req_t    req;
    logic    known;
    status_t status;
  } dir_row_t;

  typedef struct packed {
    logic [TIME_W-1:0] up_s;
    logic [TIME_W-1:0] down_s;
    logic              off;
    int                tx_idle;
    int                rx_stall;
    logic              hold;
    int                items;
  } phase_t;

  // Registers are up 20 s, down 30 s, off level 0 until the zero travel time rows.
  localparam dir_row_t DIRECTED [28] = '{
    '{'{OP_UPDATE, MOTION_UP, 7'd0, 1'b1, 20'd0}, 1'b1,
      '{15'd0, MOTION_STOP, 1'b0, 1'b0, 7'd0}},
    '{'{OP_ORDER, MOTION_UP, 7'd0, 1'b0, 20'd0}, 1'b1,
      '{15'd20, MOTION_STOP, 1'b0, 1'b0, 7'd0}},
    '{'{OP_APPLY, MOTION_UP, 7'd0, 1'b0, 20'd0}, 1'b1,
      '{15'd0, MOTION_UP, 1'b1, 1'b0, 7'd0}},
    '{'{OP_BUTTON, MOTION_DOWN, 7'd0, 1'b0, 20'd0}, 1'b1,
      '{15'd0, MOTION_UP, 1'b1, 1'b0, 7'd0}},
    '{'{OP_APPLY, MOTION_UP, 7'd0, 1'b0, 20'd0}, 1'b1,
      '{15'd0, MOTION_STOP, 1'b0, 1'b0, 7'd0}},
    '{'{OP_BUTTON, MOTION_DOWN, 7'd0, 1'b0, 20'd0}, 1'b1,
      '{15'd30, MOTION_STOP, 1'b0, 1'b0, 7'd0}},
    '{'{OP_APPLY, MOTION_UP, 7'd0, 1'b0, 20'd0}, 1'b1,
      '{15'd0, MOTION_DOWN, 1'b0, 1'b1, 7'd0}},
    '{'{OP_UPDATE, MOTION_UP, 7'd0, 1'b1, 20'd15000}, 1'b0, '0},
    '{'{OP_TARGET, MOTION_UP, 7'd100, 1'b0, 20'd0}, 1'b0, '0},
    '{'{OP_TARGET, MOTION_UP, 7'd127, 1'b0, 20'd0}, 1'b0, '0},
    '{'{OP_TARGET, MOTION_UP, 7'd50, 1'b0, 20'd0}, 1'b0, '0},
    '{'{OP_TARGET, MOTION_UP, 7'd0, 1'b0, 20'd0}, 1'b0, '0},
    '{'{OP_APPLY, MOTION_UP, 7'd0, 1'b0, 20'd0}, 1'b0, '0},
    '{'{OP_UPDATE, MOTION_UP, 7'd0, 1'b0, 20'd201}, 1'b0, '0},
    '{'{OP_UPDATE, MOTION_UP, 7'd0, 1'b0, 20'd200}, 1'b0, '0},
    '{'{OP_UPDATE, MOTION_UP, 7'd0, 1'b1, 20'hFFFFF}, 1'b1,
      '{15'd0, MOTION_UP, 1'b1, 1'b0, 7'd100}},
    '{'{OP_UPDATE, MOTION_UP, 7'd0, 1'b0, 20'hFFFFF}, 1'b1,
      '{15'd0, MOTION_UP, 1'b1, 1'b0, 7'd0}},
    '{'{OP_ORDER, ORDER_UNDEF, 7'd0, 1'b0, 20'd0}, 1'b0, '0},
    '{'{OP_APPLY, MOTION_UP, 7'd0, 1'b0, 20'd0}, 1'b0, '0},
    '{'{OP_ORDER, ORDER_UNDEF, 7'd0, 1'b0, 20'd0}, 1'b1,
      '{15'd0, MOTION_STOP, 1'b0, 1'b0, 7'd0}},
    '{'{OP_ORDER, MOTION_STOP, 7'd0, 1'b0, 20'd0}, 1'b0, '0},
    '{'{OP_SPARE5, ORDER_UNDEF, 7'd127, 1'b1, 20'hFFFFF}, 1'b1,
      '{15'd0, MOTION_STOP, 1'b0, 1'b0, 7'd0}},
    '{'{OP_SPARE6, MOTION_DOWN, 7'd100, 1'b1, 20'hFFFFF}, 1'b1,
      '{15'd0, MOTION_STOP, 1'b0, 1'b0, 7'd0}},
    '{'{OP_SPARE7, MOTION_UP, 7'd127, 1'b0, 20'hFFFFF}, 1'b1,
      '{15'd0, MOTION_STOP, 1'b0, 1'b0, 7'd0}},
    // Both travel times 0 and off level 1 from here on.
    '{'{OP_UPDATE, MOTION_UP, 7'd0, 1'b1, 20'd0}, 1'b1,
      '{15'd0, MOTION_STOP, 1'b1, 1'b1, 7'd100}},
    '{'{OP_UPDATE, MOTION_UP, 7'd0, 1'b0, 20'd5}, 1'b1,
      '{15'd0, MOTION_STOP, 1'b1, 1'b1, 7'd0}},
    '{'{OP_BUTTON, MOTION_UP, 7'd0, 1'b0, 20'd0}, 1'b1,
      '{15'd0, MOTION_STOP, 1'b1, 1'b1, 7'd0}},
    '{'{OP_APPLY, MOTION_UP, 7'd0, 1'b0, 20'd0}, 1'b1,
      '{15'd0, MOTION_UP, 1'b0, 1'b1, 7'd0}}
  };

  localparam phase_t PHASES [8] = '{
    '{8'd254, 8'd254, 1'b0, 0, 0, 1'b0, 250},
    '{8'd0, 8'd0, 1'b1, 78, 0, 1'b0, 150},
    '{ANY_TIME, ANY_TIME, 1'b0, 0, 78, 1'b0, 250},
    '{8'd1, 8'd1, 1'b1, 23, 23, 1'b0, 200},
    '{ANY_TIME, ANY_TIME, 1'b1, 0, 0, 1'b1, 150},
    '{8'd254, 8'd1, 1'b0, 23, 23, 1'b0, 200},
    '{8'd1, 8'd254, 1'b1, 0, 0, 1'b0, 175},
    '{ANY_TIME, ANY_TIME, 1'b0, 78, 0, 1'b0, 150}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  rstc_in_if  in_req ();
  rstc_out_if out_rsp ();

  roller_shutter_travel_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp)
  );

  // Shadow of the controller state and registers.
  logic [MOTION_W-1:0] want_motion = MOTION_STOP;
  logic [MOTION_W-1:0] cur_motion  = MOTION_STOP;
  logic [POS_W-1:0]    pos_pct     = '0;
  logic                up_on       = 1'b0;
  logic                down_on     = 1'b0;
  logic [TIME_W-1:0]   up_secs     = '0;
  logic [TIME_W-1:0]   down_secs   = '0;
  logic                off_lvl     = 1'b0;

  status_t status_q [$];
  int      mismatches   = 0;
  int      sent         = 0;
  int      tx_idle_pct  = 0;
  int      rx_stall_pct = 0;
  int      hold_asked   = 0;
  int      cycles       = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic status_t next_status(req_t r);
    status_t            s;
    logic [TIME_W-1:0]  secs;
    logic [POS_W-1:0]   goal;
    logic [POS_W-1:0]   dist_pct;
    logic [DIVS_W-1:0]  span;
    logic [MEAS_W:0]    whole;
    logic [MEAS_W:0]    frac;
    s = '0;
    case (r.op)
      OP_ORDER, OP_BUTTON: begin
        if (cur_motion != MOTION_STOP) begin
          want_motion = MOTION_STOP;
        end else if (r.order == MOTION_UP) begin
          want_motion = MOTION_UP;
          s.movement_time = MTIME_W'(up_secs);
        end else if (r.order == MOTION_DOWN) begin
          want_motion = MOTION_DOWN;
          s.movement_time = MTIME_W'(down_secs);
        end else begin
          // stop, and the undefined code taken as stop
          want_motion = MOTION_STOP;
        end
      end
      OP_TARGET: begin
        goal = (r.target_position > FULL_TRAVEL) ? FULL_TRAVEL : r.target_position;
        if (goal > pos_pct) begin
          dist_pct = goal - pos_pct;
          want_motion = MOTION_DOWN;
          s.movement_time = MTIME_W'(down_secs) * MTIME_W'(dist_pct);
        end else begin
          dist_pct = pos_pct - goal;
          want_motion = MOTION_UP;
          s.movement_time = MTIME_W'(up_secs) * MTIME_W'(dist_pct);
        end
      end
      OP_APPLY: begin
        up_on = (want_motion == MOTION_UP);
        down_on = (want_motion == MOTION_DOWN);
        cur_motion = want_motion;
      end
      OP_UPDATE: begin
        secs = r.direction ? down_secs : up_secs;
        if (secs == '0) begin
          // no calibration: jump to the end of travel
          pos_pct = r.direction ? FULL_TRAVEL : '0;
        end else begin
          span = DIVS_W'(secs) * DIVS_W'(10);
          whole = r.measured_time / span;
          frac = r.measured_time % span;
          if (r.direction) begin
            whole = whole + pos_pct;
            pos_pct = (whole > FULL_TRAVEL) ? FULL_TRAVEL : whole[POS_W-1:0];
          end else begin
            if (frac != '0) whole = whole + (MEAS_W+1)'(1);
            pos_pct = (whole > pos_pct) ? '0 : pos_pct - whole[POS_W-1:0];
          end
        end
      end
      default: ;
    endcase
    s.motion_state = cur_motion;
    s.up_relay = up_on ? ~off_lvl : off_lvl;
    s.down_relay = down_on ? ~off_lvl : off_lvl;
    s.position = pos_pct;
    return s;
  endfunction

  function automatic req_t rand_request();
    req_t r;
    r.op = OP_W'($urandom);
    r.order = MOTION_W'($urandom);
    r.target_position = POS_W'($urandom);
    r.direction = 1'($urandom);
    r.measured_time = MEAS_W'($urandom);
    return r;
  endfunction

  // Mostly durations that move the shutter part of the way, some exact multiples.
  function automatic logic [MEAS_W-1:0] pick_duration(logic dir);
    logic [TIME_W-1:0] secs;
    int                span;
    int                roll;
    secs = dir ? down_secs : up_secs;
    span = 10 * secs;
    roll = $urandom_range(99);
    if (secs == '0 || roll < 20) return MEAS_W'($urandom);
    if (roll < 35) return MEAS_W'(span * $urandom_range(40));
    return MEAS_W'($urandom_range(span * 50));
  endfunction

  task automatic load_settings(logic [TIME_W-1:0] up_s, logic [TIME_W-1:0] down_s,
                               logic off);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_UP_TIME;
    cfg_wdata <= up_s;
    @(posedge clk);
    cfg_idx <= CFG_DOWN_TIME;
    cfg_wdata <= down_s;
    @(posedge clk);
    cfg_idx <= CFG_OFF_LEVEL;
    cfg_wdata <= CFG_W'(off);
    @(posedge clk);
    cfg_we <= 1'b0;
    up_secs = up_s;
    down_secs = down_s;
    off_lvl = off;
  endtask

  task automatic issue_request(req_t r, logic known, status_t typed);
    int      gap;
    status_t calc;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.op <= r.op;
    in_req.order <= r.order;
    in_req.target_position <= r.target_position;
    in_req.direction <= r.direction;
    in_req.measured_time <= r.measured_time;
    do @(posedge clk); while (!in_req.ready);
    calc = next_status(r);
    status_q.push_back(known ? typed : calc);
    sent++;
  endtask

  task automatic settle();
    in_req.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int   first;
    req_t r;
    first = sent;
    while (sent - first < count) begin
      if ($urandom_range(9) < 7) begin
        // command, apply, movement report, sometimes a stop
        r = rand_request();
        case ($urandom_range(2))
          0: r.op = OP_ORDER;
          1: r.op = OP_BUTTON;
          default: r.op = OP_TARGET;
        endcase
        if ($urandom_range(7) != 0) r.order = MOTION_W'($urandom_range(1));
        if ($urandom_range(15) != 0) r.target_position = POS_W'($urandom_range(100));
        issue_request(r, 1'b0, '0);
        r = rand_request();
        r.op = OP_APPLY;
        issue_request(r, 1'b0, '0);
        r = rand_request();
        r.op = OP_UPDATE;
        r.direction = (cur_motion == MOTION_DOWN) ^ ($urandom_range(9) == 0);
        r.measured_time = pick_duration(r.direction);
        issue_request(r, 1'b0, '0);
        if ($urandom_range(2) == 0) begin
          r = rand_request();
          r.op = OP_ORDER;
          r.order = MOTION_STOP;
          issue_request(r, 1'b0, '0);
          r = rand_request();
          r.op = OP_APPLY;
          issue_request(r, 1'b0, '0);
        end
      end else begin
        issue_request(rand_request(), 1'b0, '0);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.op = '0;
    in_req.order = '0;
    in_req.target_position = '0;
    in_req.direction = 1'b0;
    in_req.measured_time = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    load_settings(8'd20, 8'd30, 1'b0);
    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (i == ZERO_TIME_ROW) begin
        settle();
        load_settings('0, '0, 1'b1);
      end
      issue_request(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].status);
    end
    for (int p = 0; p < $size(PHASES); p++) begin
      settle();
      load_settings((PHASES[p].up_s == ANY_TIME) ? TIME_W'($urandom_range(254))
                                                 : PHASES[p].up_s,
                    (PHASES[p].down_s == ANY_TIME) ? TIME_W'($urandom_range(254))
                                                   : PHASES[p].down_s,
                    PHASES[p].off);
      tx_idle_pct = PHASES[p].tx_idle;
      rx_stall_pct = PHASES[p].rx_stall;
      // long receiver hold-off while requests keep coming
      if (PHASES[p].hold) hold_asked++;
      run_random(PHASES[p].items);
    end
    settle();
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int holds_done;
    holds_done = 0;
    out_rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_asked) begin
        holds_done = hold_asked;
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got = '{out_rsp.movement_time, out_rsp.motion_state, out_rsp.up_relay,
              out_rsp.down_relay, out_rsp.position};
      if (status_q.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: result with nothing outstanding: time=%0d motion=%0d pos=%0d",
                   $time, got.movement_time, got.motion_state, got.position);
        mismatches++;
      end else begin
        want = status_q.pop_front();
        if (got != want) begin
          if (mismatches < REPORT_MAX)
            $display({"%0t: status mismatch: expected time=%0d motion=%0d up=%0d down=%0d ",
                      "pos=%0d, got time=%0d motion=%0d up=%0d down=%0d pos=%0d"},
                     $time, want.movement_time, want.motion_state, want.up_relay,
                     want.down_relay, want.position, got.movement_time, got.motion_state,
                     got.up_relay, got.down_relay, got.position);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
design/rstc_pkg.sv
design/rstc_if.sv
design/rstc_mul.sv
design/rstc_div.sv
design/roller_shutter_travel_controller.sv
design/rstc_check.sv
sim/tb_roller_shutter_travel_controller.sv
